// ----- rtl/sorted_key_state_table_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sorted key/state table
// Concurrent checks on the rising edge of clk, held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_STATE_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_STATE_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SKST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SKST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SKST_ASSERT_NOW(lbl, ante, cons, msg)
`define SKST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/skst_pkg.sv -----
// ---------------------------------------------------------------------------
// skst_pkg
// Types and constants for the sorted key/state table.
// ---------------------------------------------------------------------------
package skst_pkg;

  localparam int DEPTH      = 64;
  localparam int KEY_BITS   = 32;
  localparam int STATE_BITS = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ENTRY_W    = KEY_BITS + STATE_BITS;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] value;
    logic        skip_add;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] state_out;
  } rsp_t;

endpackage

// ----- rtl/sorted_key_state_table_top.sv -----
// ---------------------------------------------------------------------------
// sorted_key_state_table_top
// Sorted key/state table: binary search over one synchronous RAM, with
// insert and delete done by moving entries one at a time.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one transaction: add,
//   remove or check of a key. rsp channel (rsp_valid/rsp_stall/rsp) returns
//   exactly one result transaction per request, in order.
//   One request is worked on at a time; req_stall is high while the engine
//   is busy. Steps per request:
//     search : at most log2(DEPTH)+1 probes; each probe issues a RAM read
//              and then compares the key (single RAM read port).
//     shift  : each entry moved is read, then written back one slot over
//     add    : a final write of the new entry
//     plus the accept, decide and respond steps.
//   The result sits in an output register. While a result is stalled there,
//   the next finished result waits in the engine and req_stall stays high;
//   a new request is taken only after that result moves to the output reg.
//   Reset (rst, synchronous) empties the table (count to zero) and drops any
//   pending result. RAM contents are not cleared; entries past the count are
//   never read.
// ---------------------------------------------------------------------------
module sorted_key_state_table_top
  import skst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  `include "sorted_key_state_table_top_assert.svh"

  // one-hot sequencer
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PROBE = 7'b0000010,  // issue RAM read at search midpoint
    S_CMP   = 7'b0000100,  // compare returned key, narrow the range
    S_PLAN  = 7'b0001000,  // decide the outcome after the search
    S_RD    = 7'b0010000,  // shift: read source entry
    S_WR    = 7'b0100000,  // shift: write it one slot over
    S_INS   = 7'b1000000   // add: write the new entry
  } seq_t;

  seq_t state;

  // table RAM: {key, state word} per entry
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  mem_ra;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  logic [CNT_W-1:0]   entry_count;

  // request context
  logic [1:0]          op;
  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         value_q;
  logic                done;     // result ready to hand to the output reg

  // search state
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] mid_q;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] j;        // shift cursor (destination slot)

  // result under construction
  logic [1:0]  status_q;
  logic        found_q;
  logic [31:0] state_q;

  logic [KEY_BITS-1:0]   rd_key;
  logic [STATE_BITS-1:0] rd_state;
  logic                  shift_up;
  logic                  rsp_load;

  assign rd_key    = rd_data[ENTRY_W-1 -: KEY_BITS];
  assign rd_state  = rd_data[STATE_BITS-1:0];
  assign mid       = lo + ((hi - lo) >> 1);
  assign shift_up  = (op == OP_ADD);
  assign req_stall = (state != S_IDLE) || done;
  assign rsp_load  = done && (!rsp_valid || !rsp_stall);

  // RAM port control. Reads and writes are sequenced in separate states; a read
  // issued in a write state may target the written entry, but its data is unused.
  always_comb begin
    mem_ra = mid[ADDR_W-1:0];
    mem_we = 1'b0;
    mem_wa = j[ADDR_W-1:0];
    mem_wd = rd_data;
    unique case (state)
      S_RD: begin
        mem_ra = shift_up ? ADDR_W'(j - 1'b1) : ADDR_W'(j + 1'b1);
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      S_INS: begin
        mem_we = 1'b1;
        mem_wa = pos[ADDR_W-1:0];
        mem_wd = {key_q, value_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      if (rsp_load) begin
        done <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid && !req_stall) begin
            op       <= req.opcode;
            key_q    <= req.key[KEY_BITS-1:0];
            value_q  <= req.value;
            status_q <= ST_OK;
            found_q  <= 1'b0;
            state_q  <= '0;
            lo       <= '0;
            hi       <= entry_count;
            // skipped add and unused opcode answer zero at once
            if ((req.opcode == OP_ADD && req.skip_add) ||
                (req.opcode != OP_ADD && req.opcode != OP_REMOVE &&
                 req.opcode != OP_CHECK)) begin
              done <= 1'b1;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid_q <= mid;
            state <= S_CMP;
          end else begin
            pos   <= lo;
            state <= S_PLAN;
          end
        end
        S_CMP: begin
          if (rd_key == key_q) begin
            found_q <= 1'b1;
            pos     <= mid_q;
            if (op != OP_ADD) begin
              state_q <= rd_state;
            end
            state <= S_PLAN;
          end else begin
            if (key_q > rd_key) begin
              lo <= mid_q + 1'b1;
            end else begin
              hi <= mid_q;
            end
            state <= S_PROBE;
          end
        end
        S_PLAN: begin
          unique case (op)
            OP_ADD: begin
              if (found_q) begin
                status_q <= ST_DUP;
                done     <= 1'b1;
                state    <= S_IDLE;
              end else if (entry_count == CNT_W'(DEPTH)) begin
                status_q <= ST_FULL;
                done     <= 1'b1;
                state    <= S_IDLE;
              end else begin
                j     <= entry_count;
                state <= (entry_count > pos) ? S_RD : S_INS;
              end
            end
            OP_REMOVE: begin
              if (found_q) begin
                entry_count <= entry_count - 1'b1;
                j           <= pos;
                if (pos + 1'b1 < entry_count) begin
                  state <= S_RD;
                end else begin
                  done  <= 1'b1;
                  state <= S_IDLE;
                end
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end
            default: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (shift_up) begin
            j     <= j - 1'b1;
            state <= (j - 1'b1 > pos) ? S_RD : S_INS;
          end else begin
            j <= j + 1'b1;
            if (j + 1'b1 < entry_count) begin
              state <= S_RD;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_INS: begin
          entry_count <= entry_count + 1'b1;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status    <= status_q;
      rsp.found     <= found_q;
      rsp.state_out <= state_q;
    end
  end

  // checks
  `SKST_ASSERT_NOW(a_ins_room, state == S_INS, entry_count < CNT_W'(DEPTH), "insert into full table")
  `SKST_ASSERT_NOW(a_search_range, state == S_PROBE, lo <= hi && hi <= entry_count, "search range out of bounds")
  `SKST_ASSERT_NEXT(a_count_hold, state != S_PLAN && state != S_INS, $stable(entry_count), "count moved outside update step")

endmodule
